// ----- design/trcq_pkg.sv -----
package trcq_pkg;

  // Field widths of one input item.
  localparam int unsigned CellW = 8;
  localparam int unsigned PixW  = 12;

  // Tile coordinates and counts: a pixel value shifted down, plus one tile for a
  // misaligned edge, plus a start column, all fit in one more bit than a pixel.
  localparam int unsigned CoordW = PixW + 1;

  // Operation codes carried on the opcode field.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ----- design/trcq_map.sv -----
module trcq_map #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  // One bit per tile, one write and one registered read per cycle.
  logic mem_q [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tile_rect_collision_query_top.sv -----
// Tile map collision query.
//
// The block holds a MAP_DIM x MAP_DIM map with one blocking bit per tile.
// A command transfer happens at a rising edge where start is high and busy is
// low. With opcode write, tile (cell_x_i, cell_y_i) is set or cleared; a tile
// outside the map is left alone. With opcode query, the pixel rectangle is
// turned into a span of tiles of 2**TILE_SHIFT pixels and the span is scanned
// one tile at a time through the single read port of the map memory.
// Every command gives one result transfer: done_o is high for exactly one
// cycle with collides_o, which is 0 for a write. The receiver cannot stall,
// and busy is low again in the cycle that shows the result.
// A write passes through the write state. A query passes through setup, then a row
// step per scanned row and a read and a check step per scanned tile, and stops
// at the first blocked tile; a scan that finds no blocked tile ends in one more
// row step, so an empty span finishes right after setup and one row step.
// The read-then-check walk over the map memory sets the time a query takes.
// After reset the block runs a clearing pass that writes one tile per cycle,
// through all MAP_DIM*MAP_DIM tiles, with busy high; then every tile is free.
module tile_rect_collision_query_top #(
  parameter int unsigned MAP_DIM    = 256,
  parameter int unsigned TILE_SHIFT = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode_i,
  input  logic [trcq_pkg::CellW-1:0]   cell_x_i,
  input  logic [trcq_pkg::CellW-1:0]   cell_y_i,
  input  logic                         cell_value_i,
  input  logic [trcq_pkg::PixW-1:0]    rect_left_i,
  input  logic [trcq_pkg::PixW-1:0]    rect_top_i,
  input  logic [trcq_pkg::PixW-1:0]    rect_width_i,
  input  logic [trcq_pkg::PixW-1:0]    rect_height_i,
  output logic                         done_o,
  output logic                         collides_o
);
  import trcq_pkg::*;

  localparam int unsigned Depth = MAP_DIM * MAP_DIM;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  // Width of a product of a coordinate and the map dimension.
  localparam int unsigned ProdW = CoordW + $clog2(MAP_DIM + 1);
  localparam logic [PixW-1:0]   TileMask = PixW'((1 << TILE_SHIFT) - 1);
  localparam logic [CoordW-1:0] DimC     = CoordW'(MAP_DIM);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0]  DimA     = AddrW'(MAP_DIM);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_ROW   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_WRITE = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [AddrW-1:0]  row_base_q, row_base_d;
  logic [CoordW-1:0] x_q, x_d;
  logic [CoordW-1:0] y_q, y_d;
  logic [CoordW-1:0] col0_q, col0_d;
  logic [CoordW-1:0] cols_q, cols_d;
  logic [CoordW-1:0] rows_q, rows_d;
  logic [CoordW-1:0] col_end_q, col_end_d;
  logic [CoordW-1:0] row_end_q, row_end_d;
  logic              wr_ok_q, wr_ok_d;
  logic              wval_q, wval_d;
  logic              done_q, done_d;
  logic              collides_q, collides_d;

  logic              accept;
  logic [ProdW-1:0]  waddr_wide;
  logic [CoordW-1:0] col_sum;
  logic [CoordW-1:0] row_sum;
  logic [CoordW-1:0] x_next;
  logic              map_we;
  logic              map_wdata;
  logic              map_rdata;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Linear address of a written tile; only used when the tile is in the map.
  assign waddr_wide = ProdW'(cell_y_i) * ProdW'(MAP_DIM) + ProdW'(cell_x_i);

  assign col_sum = col0_q + cols_q;
  assign row_sum = y_q + rows_q;
  assign x_next  = x_q + CoordW'(1);

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    row_base_d = row_base_q;
    x_d        = x_q;
    y_d        = y_q;
    col0_d     = col0_q;
    cols_d     = cols_q;
    rows_d     = rows_q;
    col_end_d  = col_end_q;
    row_end_d  = row_end_q;
    wr_ok_d    = wr_ok_q;
    wval_d     = wval_q;
    done_d     = 1'b0;
    collides_d = collides_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the whole map once, writing each tile free.
        addr_d = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_WRITE) begin
            addr_d  = AddrW'(waddr_wide);
            wr_ok_d = (32'(cell_x_i) < MAP_DIM) && (32'(cell_y_i) < MAP_DIM);
            wval_d  = cell_value_i;
            state_d = ST_WRITE;
          end else begin
            // A misaligned edge adds one tile to the count, as in the original scheme.
            col0_d  = CoordW'(rect_left_i >> TILE_SHIFT);
            y_d     = CoordW'(rect_top_i >> TILE_SHIFT);
            cols_d  = CoordW'(rect_width_i >> TILE_SHIFT)
                    + CoordW'((rect_left_i & TileMask) != '0);
            rows_d  = CoordW'(rect_height_i >> TILE_SHIFT)
                    + CoordW'((rect_top_i & TileMask) != '0);
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // Clip the span to the map so that tiles never wrap into the next row.
        col_end_d  = (col_sum > DimC) ? DimC : col_sum;
        row_end_d  = (row_sum > DimC) ? DimC : row_sum;
        row_base_d = AddrW'(ProdW'(y_q) * ProdW'(MAP_DIM));
        state_d    = ST_ROW;
      end
      ST_ROW: begin
        if ((y_q >= row_end_q) || (col0_q >= col_end_q)) begin
          collides_d = 1'b0;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          x_d     = col0_q;
          addr_d  = row_base_q + AddrW'(col0_q);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (map_rdata) begin
          collides_d = 1'b1;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else if (x_next < col_end_q) begin
          x_d     = x_next;
          addr_d  = addr_q + AddrW'(1);
          state_d = ST_READ;
        end else begin
          y_d        = y_q + CoordW'(1);
          row_base_d = row_base_q + DimA;
          state_d    = ST_ROW;
        end
      end
      ST_WRITE: begin
        collides_d = 1'b0;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
        addr_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_base_q <= row_base_d;
    x_q        <= x_d;
    y_q        <= y_d;
    col0_q     <= col0_d;
    cols_q     <= cols_d;
    rows_q     <= rows_d;
    col_end_q  <= col_end_d;
    row_end_q  <= row_end_d;
    wr_ok_q    <= wr_ok_d;
    wval_q     <= wval_d;
    collides_q <= collides_d;
  end

  // The clearing pass and tile writes share the single write port.
  assign map_we    = (state_q == ST_CLEAR) || ((state_q == ST_WRITE) && wr_ok_q);
  assign map_wdata = (state_q == ST_WRITE) ? wval_q : 1'b0;

  trcq_map #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (addr_q),
    .wdata_i (map_wdata),
    .raddr_i (addr_q),
    .rdata_o (map_rdata)
  );

  assign done_o     = done_q;
  assign collides_o = collides_q;

  // A result only follows a cycle in which the block was working.
  a_done_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a command in flight");

  // A reported collision comes straight from a blocked tile that was read.
  a_hit_from_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && collides_o) |-> ($past(state_q) == ST_CHECK && $past(map_rdata)))
    else $error("collision reported without a blocked tile");

  // An accepted command always leaves the block busy in the cycle after the transfer.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block idle right after a command transfer");

  // Reads stay inside the clipped span.
  a_read_in_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ((x_q < col_end_q) && (y_q < row_end_q)
                              && (col_end_q <= DimC) && (row_end_q <= DimC)))
    else $error("map read outside the clipped span");

endmodule
